/* rtl/i2c_master_bit_engine_defines.svh */
// assertion macros for the i2c master bit engine
// needs clk and arst_n in the scope of each use
`ifndef I2C_MASTER_BIT_ENGINE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_DEFINES_SVH

// condition holds at every edge out of reset
`define I2CMBE_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("i2cmbe assertion failed");

// consequent holds in the cycle after the antecedent
`define I2CMBE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cmbe assertion failed");

`endif

/* rtl/i2cmbe_pkg.sv */
// shared types and constants for the i2c master bit engine
// no dependencies
`default_nettype none

package i2cmbe_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int PH_W = 5;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [PH_W-1:0] LAST_SHORT = PH_W'(2);
	localparam logic [PH_W-1:0] LAST_ACK = PH_W'(3);
	localparam logic [PH_W-1:0] LAST_BYTE = PH_W'(2 * BITS_PER_BYTE + 1);

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_ACK   = 3'd4,
		CMD_NACK  = 3'd5,
		CMD_RACK  = 3'd6
	} cmd_e;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] tx_byte;
		logic [7:0] slave_bits;
	} in_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic [7:0] rx_byte;
		logic       nack_seen;
		logic       last_phase;
	} out_item_t;

	// classified request as held in the queue
	typedef struct packed {
		cmd_e            kind;
		logic [7:0]      data;
		logic [PH_W-1:0] last_idx;
	} desc_t;

endpackage

`default_nettype wire

/* rtl/i2cmbe_front.sv */
// front end: accepts requests, drops undefined codes, classifies into descriptors
// depends on i2cmbe_pkg
`default_nettype none

module i2cmbe_front import i2cmbe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t command,
	output logic          desc_valid,
	output desc_t         desc,
	input  wire logic     desc_ready
);

	logic  valid_s1;
	desc_t desc_s1;
	logic  accept;
	logic  keep;
	desc_t desc_new;

	assign full = valid_s1 && !desc_ready;
	assign accept = push && !full;

	always_comb begin
		keep = 1'b1;
		desc_new.kind = cmd_e'(command.cmd);
		desc_new.data = command.slave_bits;
		desc_new.last_idx = LAST_SHORT;
		case (command.cmd)
			CMD_START, CMD_STOP: begin
				desc_new.last_idx = LAST_SHORT;
			end
			CMD_WRITE: begin
				desc_new.data = command.tx_byte;
				desc_new.last_idx = LAST_BYTE;
			end
			CMD_READ: begin
				desc_new.last_idx = LAST_BYTE;
			end
			CMD_ACK, CMD_NACK, CMD_RACK: begin
				desc_new.last_idx = LAST_ACK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= keep;
		end else if (desc_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_new;
		end
	end

	assign desc_valid = valid_s1;
	assign desc = desc_s1;

endmodule

`default_nettype wire

/* rtl/i2cmbe_queue.sv */
// short descriptor queue between front and back
// depends on i2cmbe_pkg
`default_nettype none

module i2cmbe_queue import i2cmbe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  wr_valid,
	output logic       wr_ready,
	input  wire desc_t wr_desc,
	output logic       rd_valid,
	output desc_t      rd_desc,
	input  wire logic  rd_pop
);

	desc_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = count_q != QCNT_W'(QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_desc = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

endmodule

`default_nettype wire

/* rtl/i2cmbe_back.sv */
// back end: phase sequencer, line state and result register
// depends on i2cmbe_pkg and i2c_master_bit_engine_defines.svh
`default_nettype none

`include "i2c_master_bit_engine_defines.svh"

module i2cmbe_back import i2cmbe_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  head_valid,
	input  wire desc_t head,
	output logic       head_pop,
	output logic       empty,
	input  wire logic  pop,
	output out_item_t  phase
);

	logic [PH_W-1:0] phase_q;
	logic            scl_now_q;
	logic            sda_now_q;
	logic            drv_now_q;
	logic            out_valid_q;
	out_item_t       out_q;
	out_item_t       ph;
	logic            advance;
	logic            is_last;
	logic [PH_W-1:0] pm1;
	logic [2:0]      bit_idx;
	logic            tx_bit;
	logic            ack_bit;

	assign advance = head_valid && (!out_valid_q || pop);
	assign is_last = phase_q == head.last_idx;
	assign head_pop = advance && is_last;
	assign pm1 = phase_q - 1'b1;
	assign bit_idx = ~pm1[3:1];
	assign tx_bit = head.data[bit_idx];
	assign ack_bit = head.kind == CMD_NACK;

	always_comb begin
		ph = '0;
		ph.last_phase = is_last;
		ph.scl_level = 1'b0;
		ph.sda_level = 1'b1;
		ph.sda_drive = 1'b1;
		case (head.kind)
			CMD_START: begin
				ph.scl_level = (phase_q == '0) ? scl_now_q : 1'b1;
				ph.sda_level = phase_q != LAST_SHORT;
			end
			CMD_STOP: begin
				ph.scl_level = phase_q != '0;
				ph.sda_level = phase_q == LAST_SHORT;
			end
			CMD_WRITE: begin
				if (phase_q == '0) begin
					ph.sda_level = sda_now_q;
				end else if (is_last) begin
					ph.sda_level = head.data[0];
				end else begin
					ph.scl_level = ~phase_q[0];
					ph.sda_level = tx_bit;
				end
			end
			CMD_READ: begin
				if (phase_q == '0) begin
					ph.sda_level = sda_now_q;
					ph.sda_drive = drv_now_q;
				end else if (is_last) begin
					ph.rx_byte = head.data;
				end else begin
					ph.scl_level = ~phase_q[0];
					ph.sda_drive = 1'b0;
				end
			end
			CMD_ACK, CMD_NACK: begin
				if (phase_q == '0) begin
					ph.sda_level = sda_now_q;
					ph.sda_drive = drv_now_q;
				end else begin
					ph.scl_level = phase_q == LAST_SHORT;
					ph.sda_level = ack_bit;
				end
			end
			CMD_RACK: begin
				if (phase_q == '0) begin
					ph.sda_level = sda_now_q;
					ph.sda_drive = drv_now_q;
				end else if (is_last) begin
					ph.nack_seen = head.data[BITS_PER_BYTE-1];
				end else begin
					ph.scl_level = phase_q == LAST_SHORT;
					ph.sda_drive = 1'b0;
				end
			end
			default: begin
				ph = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			scl_now_q <= 1'b1;
			sda_now_q <= 1'b1;
			drv_now_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			phase_q <= is_last ? '0 : phase_q + 1'b1;
			scl_now_q <= ph.scl_level;
			sda_now_q <= ph.sda_level;
			drv_now_q <= ph.sda_drive;
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= ph;
		end
	end

	assign empty = !out_valid_q;
	assign phase = out_q;

	// phase counter stays inside the current request
	`I2CMBE_ASSERT_ALWAYS(a_phase_range, !head_valid || phase_q <= head.last_idx)
	// counter rests at zero between requests
	`I2CMBE_ASSERT_ALWAYS(a_phase_idle, head_valid || phase_q == '0)
	// received data only on a final phase
	`I2CMBE_ASSERT_ALWAYS(a_rx_last, !out_valid_q || out_q.rx_byte == '0 || out_q.last_phase)
	// line state follows the phase just emitted
	`I2CMBE_ASSERT_NEXT(a_line_track, advance,
		scl_now_q == out_q.scl_level && drv_now_q == out_q.sda_drive)

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_engine.sv */
// i2c master bit engine: the block's top level
// usage:
//   requests enter on command with push; a request is taken at an edge with
//   push high and full low. codes start, stop, write byte, read byte, ack,
//   nack and read ack are carried out; the undefined code is dropped.
//   each request yields a run of line phases on phase (scl, sda, drive,
//   rx_byte, nack_seen, last_phase); the oldest phase waits while empty is
//   low and is taken at an edge with pop high and empty low.
//   start and stop give 3 phases, ack, nack and read ack 4, write and read
//   byte 18; the phase sequencer emits one phase per cycle while the
//   receiver takes phases, and requests follow without gap while the queue
//   holds the next one. the first phase of a request passes the front
//   register, then the queue write, then the result register before it shows.
//   a four-deep queue parts the front from the sequencer; when the receiver
//   holds off pop the result register holds, the sequencer stops, and once
//   the queue and the front register fill, full rises.
//   reset empties everything and sets the line state to scl high, sda high,
//   sda released.
// depends on i2cmbe_pkg, i2cmbe_front, i2cmbe_queue, i2cmbe_back
`default_nettype none

module i2c_master_bit_engine import i2cmbe_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t command,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     phase
);

	logic  f_valid;
	logic  f_ready;
	desc_t f_desc;
	logic  h_valid;
	desc_t h_desc;
	logic  h_pop;

	i2cmbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.desc_valid (f_valid),
		.desc       (f_desc),
		.desc_ready (f_ready)
	);

	i2cmbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_desc  (f_desc),
		.rd_valid (h_valid),
		.rd_desc  (h_desc),
		.rd_pop   (h_pop)
	);

	i2cmbe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (h_valid),
		.head       (h_desc),
		.head_pop   (h_pop),
		.empty      (empty),
		.pop        (pop),
		.phase      (phase)
	);

endmodule

`default_nettype wire

/* sim/i2c_master_bit_engine_checker.sv */
// line phase checker for the i2c master bit engine: watches both queue ports,
// predicts the scl/sda phase runs of every accepted request and compares them
// depends on i2cmbe_pkg
`timescale 1ns / 100ps

module i2c_master_bit_engine_checker import i2cmbe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  logic      full,
	input  in_item_t  command,
	input  logic      empty,
	input  logic      pop,
	input  out_item_t phase,
	output int        fail_count,
	output int        pending
);

	out_item_t phases_due[$];
	logic      line_scl = 1'b1;
	logic      line_sda = 1'b1;
	logic      line_drv = 1'b0;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic add_phase(input logic scl, input logic sda, input logic drv,
		input logic [7:0] rx, input logic nack, input logic last);
		phases_due.push_back('{scl_level: scl, sda_level: sda, sda_drive: drv,
			rx_byte: rx, nack_seen: nack, last_phase: last});
		line_scl = scl;
		line_sda = sda;
		line_drv = drv;
	endtask

	task automatic predict_line_phases(input in_item_t req);
		logic [7:0] shreg;
		logic       b;
		shreg = req.tx_byte;
		b = 1'b0;
		case (cmd_e'(req.cmd))
			CMD_START: begin
				add_phase(line_scl, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
				add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
				add_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1);
			end
			CMD_STOP: begin
				add_phase(1'b0, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
				add_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
				add_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b1);
			end
			CMD_WRITE: begin
				add_phase(1'b0, line_sda, 1'b1, 8'h00, 1'b0, 1'b0);
				for (int i = 0; i < BITS_PER_BYTE; i++) begin
					b = shreg[7];
					shreg = shreg << 1;
					add_phase(1'b0, b, 1'b1, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, b, 1'b1, 8'h00, 1'b0, 1'b0);
				end
				add_phase(1'b0, b, 1'b1, 8'h00, 1'b0, 1'b1);
			end
			CMD_READ: begin
				add_phase(1'b0, line_sda, line_drv, 8'h00, 1'b0, 1'b0);
				for (int i = 0; i < BITS_PER_BYTE; i++) begin
					add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
					add_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
				end
				// bits sampled msb first, so the byte read is the slave byte itself
				add_phase(1'b0, 1'b1, 1'b1, req.slave_bits, 1'b0, 1'b1);
			end
			CMD_ACK, CMD_NACK: begin
				b = (cmd_e'(req.cmd) == CMD_NACK);
				add_phase(1'b0, line_sda, line_drv, 8'h00, 1'b0, 1'b0);
				add_phase(1'b0, b, 1'b1, 8'h00, 1'b0, 1'b0);
				add_phase(1'b1, b, 1'b1, 8'h00, 1'b0, 1'b0);
				add_phase(1'b0, b, 1'b1, 8'h00, 1'b0, 1'b1);
			end
			CMD_RACK: begin
				add_phase(1'b0, line_sda, line_drv, 8'h00, 1'b0, 1'b0);
				add_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
				add_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
				add_phase(1'b0, 1'b1, 1'b1, 8'h00, req.slave_bits[7], 1'b1);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (push && !full)
				predict_line_phases(command);
			if (pop && !empty) begin
				if (phases_due.size() == 0) begin
					$display("%0t ns: unexpected line phase, expected none actual %h",
						$time, phase);
					fail_count++;
				end else begin
					want = phases_due.pop_front();
					check_field("scl_level", 8'(want.scl_level), 8'(phase.scl_level));
					check_field("sda_level", 8'(want.sda_level), 8'(phase.sda_level));
					check_field("sda_drive", 8'(want.sda_drive), 8'(phase.sda_drive));
					check_field("rx_byte", want.rx_byte, phase.rx_byte);
					check_field("nack_seen", 8'(want.nack_seen), 8'(phase.nack_seen));
					check_field("last_phase", 8'(want.last_phase), 8'(phase.last_phase));
				end
			end
			pending <= phases_due.size();
		end
	end

endmodule

/* sim/i2c_master_bit_engine_tb.sv */
// testbench top for the i2c master bit engine: clock, reset, request and
// pop stimulus with random gaps, and the verdict
// depends on i2cmbe_pkg, i2c_master_bit_engine, i2c_master_bit_engine_checker
`timescale 1ns / 100ps

module i2c_master_bit_engine_tb import i2cmbe_pkg::*; ();

	localparam logic [2:0] CMD_UNDEF = 3'd7;
	localparam int         ITEM_COUNT = 470;
	localparam int         CYCLE_LIMIT = 1500000;
	localparam int         HOLD_CYCLES = 400;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  command;
	logic      empty;
	logic      pop;
	out_item_t phase;
	int        fail_count;
	int        pending;
	int        accepted_cnt = 0;
	int        real_items = 0;
	int        cycle_cnt = 0;

	i2c_master_bit_engine u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.command (command),
		.empty   (empty),
		.pop     (pop),
		.phase   (phase)
	);

	i2c_master_bit_engine_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.command    (command),
		.empty      (empty),
		.pop        (pop),
		.phase      (phase),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic offer(input logic [2:0] code, input logic [7:0] tx, input logic [7:0] sb);
		int unsigned r;
		int unsigned gap;
		push <= 1'b1;
		command <= '{cmd: code, tx_byte: tx, slave_bits: sb};
		@(posedge clk);
		while (full) @(posedge clk);
		accepted_cnt <= accepted_cnt + 1;
		if (code != CMD_UNDEF)
			real_items++;
		r = $urandom_range(0, 99);
		gap = (r < 60) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] slave_ack_bits();
		// mostly ack, now and then nack
		return {($urandom_range(0, 3) == 0), 7'($urandom_range(0, 127))};
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// start, address, then writes or reads; a repeated start may follow, and stop ends it
	task automatic run_transfer();
		int unsigned n;
		bit          rd;
		bit          again;
		again = 1'b1;
		offer(CMD_START, rand_byte(), rand_byte());
		while (again) begin
			offer(CMD_WRITE, rand_byte(), rand_byte());
			offer(CMD_RACK, rand_byte(), slave_ack_bits());
			rd = 1'($urandom_range(0, 1));
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++) begin
				if (rd) begin
					offer(CMD_READ, rand_byte(), rand_byte());
					offer((i == n - 1) ? CMD_NACK : CMD_ACK, rand_byte(), rand_byte());
				end else begin
					offer(CMD_WRITE, rand_byte(), rand_byte());
					offer(CMD_RACK, rand_byte(), slave_ack_bits());
				end
			end
			again = ($urandom_range(0, 4) == 0);
			if (again)
				offer(CMD_START, rand_byte(), rand_byte());
		end
		offer(CMD_STOP, rand_byte(), rand_byte());
	endtask

	// receiver side: random pop gaps and one long hold-off
	initial begin
		int unsigned r;
		int unsigned gap;
		int unsigned run;
		bit          held;
		held = 1'b0;
		pop <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held && accepted_cnt >= 60) begin
				held = 1'b1;
				gap = HOLD_CYCLES;
			end else begin
				r = $urandom_range(0, 99);
				gap = (r < 55) ? 0 : (r < 93) ? $urandom_range(1, 4) : $urandom_range(10, 40);
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			r = $urandom_range(0, 9);
			run = (r < 2) ? $urandom_range(40, 120) : $urandom_range(1, 6);
			pop <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// sender side
	initial begin
		int unsigned next_drain;
		int unsigned r;
		arst_n <= 1'b0;
		push <= 1'b0;
		command <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(CMD_START, 8'h00, 8'h00);
		offer(CMD_WRITE, 8'h00, 8'hff);
		offer(CMD_RACK, 8'hff, 8'h00);
		offer(CMD_WRITE, 8'hff, 8'h00);
		offer(CMD_RACK, 8'h00, 8'h80);
		offer(CMD_WRITE, 8'ha5, 8'h5a);
		offer(CMD_READ, 8'h00, 8'hff);
		offer(CMD_ACK, 8'hff, 8'hff);
		offer(CMD_READ, 8'hff, 8'h00);
		offer(CMD_NACK, 8'h00, 8'h00);
		offer(CMD_READ, 8'h5a, 8'h5a);
		// repeated start with scl low
		offer(CMD_START, 8'hff, 8'hff);
		offer(CMD_RACK, 8'h80, 8'h7f);
		offer(CMD_STOP, 8'h00, 8'h00);
		offer(CMD_STOP, 8'hff, 8'hff);
		offer(CMD_UNDEF, 8'hff, 8'hff);
		offer(CMD_START, 8'h00, 8'hff);
		offer(CMD_START, 8'hff, 8'h00);
		offer(CMD_NACK, 8'h00, 8'hff);
		offer(CMD_ACK, 8'hff, 8'h00);
		offer(CMD_STOP, 8'h00, 8'h00);
		wait_drained();

		next_drain = 200;
		while (real_items < ITEM_COUNT) begin
			r = $urandom_range(0, 99);
			if (r < 80)
				run_transfer();
			else
				repeat ($urandom_range(1, 3))
					offer(3'($urandom_range(0, 7)), rand_byte(), rand_byte());
			if (real_items >= next_drain) begin
				wait_drained();
				next_drain += 150;
			end
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (pending != 0)
			$display("%0t ns: %0d line phases still expected", $time, pending);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

/* i2c_master_bit_engine.f */
+incdir+rtl
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_front.sv
rtl/i2cmbe_queue.sv
rtl/i2cmbe_back.sv
rtl/i2c_master_bit_engine.sv
sim/i2c_master_bit_engine_checker.sv
sim/i2c_master_bit_engine_tb.sv
